// ===== hw/rtl/mffn_pkg.sv =====
// mffn_pkg: shared types, constants and small tables of the maze flood fill navigator
// no dependencies; imported by the controller, datapath and top level
package mffn_pkg;

  localparam int CELLS = 256;

  localparam logic [7:0] FAR       = 8'd255;
  localparam logic [2:0] MOVE_NONE = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_GOAL_X    = 3'd1;
  localparam logic [2:0] CFG_GOAL_Y    = 3'd2;
  localparam logic [2:0] CFG_START_X   = 3'd3;
  localparam logic [2:0] CFG_START_Y   = 3'd4;

  localparam logic [8:0] THRESHOLD_RST = 9'd15;
  localparam logic [3:0] GOAL_RST      = 4'd9;
  localparam logic [3:0] START_RST     = 4'd0;

  // sequencer operations, also the controller state codes
  localparam logic [3:0] OP_IDLE     = 4'd0;
  localparam logic [3:0] OP_START    = 4'd1;
  localparam logic [3:0] OP_SENSE_RD = 4'd2;
  localparam logic [3:0] OP_SENSE_WR = 4'd3;
  localparam logic [3:0] OP_CLR      = 4'd4;
  localparam logic [3:0] OP_SEED     = 4'd5;
  localparam logic [3:0] OP_NEXT     = 4'd6;
  localparam logic [3:0] OP_CELL_RD  = 4'd7;
  localparam logic [3:0] OP_CELL_LAT = 4'd8;
  localparam logic [3:0] OP_NB_RD    = 4'd9;
  localparam logic [3:0] OP_NB_CHK   = 4'd10;
  localparam logic [3:0] OP_DEC_RD   = 4'd11;
  localparam logic [3:0] OP_DEC_LAT  = 4'd12;
  localparam logic [3:0] OP_DN_RD    = 4'd13;
  localparam logic [3:0] OP_DN_LAT   = 4'd14;
  localparam logic [3:0] OP_MOVE     = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] idx;
  } mffn_cmd_t;

  typedef struct packed {
    logic q_more;
    logic clr_last;
    logic restart;
    logic sense;
    logic out_free;
  } mffn_sts_t;

  // heading change for each move: forward, left, right, back
  function automatic logic [1:0] turn_of_move(input logic [1:0] m);
    logic [1:0] t;
    case (m)
      2'd0: t = 2'd0;
      2'd1: t = 2'd3;
      2'd2: t = 2'd1;
      default: t = 2'd2;
    endcase
    return t;
  endfunction

  // move for a direction relative to the heading
  function automatic logic [1:0] move_of_rel(input logic [1:0] r);
    logic [1:0] m;
    case (r)
      2'd0: m = 2'd0;
      2'd1: m = 2'd2;
      2'd2: m = 2'd3;
      default: m = 2'd1;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/mffn_in_if.sv =====
// mffn_in_if: input channel of the navigator, valid/ready with one step request
// no dependencies
interface mffn_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic       sense_walls;
  logic [8:0] range_front;
  logic [8:0] range_left;
  logic [8:0] range_right;

  modport source (output valid, restart, sense_walls, range_front, range_left, range_right,
                  input ready);
  modport sink (input valid, restart, sense_walls, range_front, range_left, range_right,
                output ready);
endinterface

// ===== hw/rtl/mffn_out_if.sv =====
// mffn_out_if: result channel of the navigator, valid/ready with one step result
// no dependencies
interface mffn_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] move;
  logic [3:0] pos_x;
  logic [3:0] pos_y;
  logic [1:0] heading;
  logic       at_goal;
  logic [7:0] cell_distance;

  modport source (output valid, move, pos_x, pos_y, heading, at_goal, cell_distance,
                  input ready);
  modport sink (input valid, move, pos_x, pos_y, heading, at_goal, cell_distance,
                output ready);
endinterface

// ===== hw/rtl/mffn_ram.sv =====
// mffn_ram: generic single write, single read RAM with registered read data
// no dependencies
module mffn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mffn_ctrl.sv =====
// mffn_ctrl: sequencer for one navigation step (sense, clear, flood, decide, move)
// depends on mffn_pkg
module mffn_ctrl
  import mffn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  mffn_sts_t sts,
  output mffn_cmd_t cmd
);

  logic [3:0] state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      OP_IDLE: begin
        if (in_valid) state_nxt = OP_START;
      end
      OP_START: begin
        idx_nxt   = 3'd0;
        state_nxt = (sts.sense && !sts.restart) ? OP_SENSE_RD : OP_CLR;
      end
      OP_SENSE_RD: state_nxt = OP_SENSE_WR;
      OP_SENSE_WR: begin
        if (idx_r == 3'd4) begin
          state_nxt = OP_CLR;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = OP_SENSE_RD;
        end
      end
      OP_CLR: begin
        if (sts.clr_last) state_nxt = OP_SEED;
      end
      OP_SEED: state_nxt = OP_NEXT;
      OP_NEXT: state_nxt = sts.q_more ? OP_CELL_RD : OP_DEC_RD;
      OP_CELL_RD: state_nxt = OP_CELL_LAT;
      OP_CELL_LAT: begin
        idx_nxt   = 3'd0;
        state_nxt = OP_NB_RD;
      end
      OP_NB_RD: state_nxt = OP_NB_CHK;
      OP_NB_CHK: begin
        if (idx_r == 3'd3) begin
          state_nxt = OP_NEXT;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = OP_NB_RD;
        end
      end
      OP_DEC_RD: state_nxt = OP_DEC_LAT;
      OP_DEC_LAT: begin
        idx_nxt   = 3'd0;
        state_nxt = sts.restart ? OP_MOVE : OP_DN_RD;
      end
      OP_DN_RD: state_nxt = OP_DN_LAT;
      OP_DN_LAT: begin
        if (idx_r == 3'd3) begin
          state_nxt = OP_MOVE;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = OP_DN_RD;
        end
      end
      OP_MOVE: begin
        if (sts.out_free) state_nxt = OP_IDLE;
      end
      default: state_nxt = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OP_IDLE;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign cmd.op  = state_r;
  assign cmd.idx = idx_r;

  a_sense_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == OP_SENSE_WR) |-> (idx_r <= 3'd4))
    else $error("sense target index out of range");
  a_nb_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == OP_NB_CHK || state_r == OP_DN_LAT) |-> (idx_r <= 3'd3))
    else $error("direction index out of range");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == OP_IDLE && in_valid) |=> (state_r == OP_START))
    else $error("transfer not followed by start");

endmodule

// ===== hw/rtl/mffn_dp.sv =====
// mffn_dp: navigator datapath: pose, configuration, wall/distance/queue memories, decision
// depends on mffn_pkg and mffn_ram
module mffn_dp
  import mffn_pkg::*;
#(
  parameter int MAZE_DIM = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mffn_cmd_t  cmd,
  output mffn_sts_t  sts,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_fire,
  input  logic       in_restart,
  input  logic       in_sense_walls,
  input  logic [8:0] in_range_front,
  input  logic [8:0] in_range_left,
  input  logic [8:0] in_range_right,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [2:0] out_move,
  output logic [3:0] out_pos_x,
  output logic [3:0] out_pos_y,
  output logic [1:0] out_heading,
  output logic       out_at_goal,
  output logic [7:0] out_cell_distance
);

  localparam logic [3:0] DIM_MAX = 4'(MAZE_DIM - 1);

  typedef struct packed {
    logic       ok;
    logic [3:0] x;
    logic [3:0] y;
  } nb_t;

  function automatic nb_t nb(input logic [3:0] x, input logic [3:0] y, input logic [1:0] d);
    nb_t r;
    r.x = x;
    r.y = y;
    r.ok = 1'b0;
    case (d)
      2'd0: begin r.ok = (y < DIM_MAX); r.y = y + 4'd1; end
      2'd1: begin r.ok = (x < DIM_MAX); r.x = x + 4'd1; end
      2'd2: begin r.ok = (y != 4'd0);   r.y = y - 4'd1; end
      default: begin r.ok = (x != 4'd0); r.x = x - 4'd1; end
    endcase
    return r;
  endfunction

  function automatic logic [3:0] clamp_dim(input logic [3:0] v);
    return (v > DIM_MAX) ? DIM_MAX : v;
  endfunction

  // boundary walls: bit0 north, bit1 east, bit2 south, bit3 west
  function automatic logic [3:0] wall_rst(input logic [7:0] a);
    return {a[3:0] == 4'd0, a[7:4] == 4'd0, a[3:0] == DIM_MAX, a[7:4] == DIM_MAX};
  endfunction

  // configuration
  logic [8:0] thr_r;
  logic [3:0] goal_x_r, goal_y_r, start_x_r, start_y_r;
  // pose and step context
  logic [3:0] rx_r, ry_r;
  logic [1:0] rh_r;
  logic       restart_r, sense_r;
  logic [3:0] sbits_r;
  // flood state
  logic [7:0] clr_r;
  logic [8:0] head_r, tail_r;
  logic [7:0] c_r, n_r;
  logic [3:0] cw_r;
  logic [8:0] nd_r;
  logic       nok_r;
  // decision state
  logic [7:0] cur_r;
  logic [3:0] pw_r;
  logic       dok_r;
  logic [7:0] reld_r [4];
  // result register
  logic       out_valid_r;
  logic [2:0] move_r;
  logic [3:0] px_r, py_r;
  logic [1:0] ph_r;
  logic       goal_hit_r;
  logic [7:0] dist_out_r;

  // memory ports
  logic       w_we, d_we, q_we;
  logic [7:0] w_wa, w_ra, d_wa, d_ra, q_wa, q_ra;
  logic [3:0] w_wd, w_rd;
  logic [7:0] d_wd, d_rd, q_wd, q_rd;
  logic [CELLS-1:0] wv_r;
  logic       wv_rd_r;
  logic [7:0] w_ra_q_r;
  logic [3:0] wall_eff;

  logic [3:0] gx, gy;
  logic [7:0] pose_addr;
  logic       out_free, load_out;

  // sense target
  logic [1:0] sd;
  nb_t        nbs;
  logic [7:0] tgt_addr;
  logic [3:0] tgt_mask;
  logic       tgt_ok;

  nb_t        nbc, nbp, nbm;
  logic [3:0] sbits_in;

  // decision
  logic [7:0] least;
  logic [2:0] mv;
  logic       found;
  logic [1:0] hnew;

  assign gx        = clamp_dim(goal_x_r);
  assign gy        = clamp_dim(goal_y_r);
  assign pose_addr = {ry_r, rx_r};
  assign wall_eff  = wv_rd_r ? w_rd : wall_rst(w_ra_q_r);
  assign out_free  = !out_valid_r || out_ready;
  assign load_out  = (cmd.op == OP_MOVE) && out_free;

  assign sts.q_more   = (head_r < tail_r) && !head_r[8];
  assign sts.clr_last = (clr_r == 8'hFF);
  assign sts.restart  = restart_r;
  assign sts.sense    = sense_r;
  assign sts.out_free = out_free;

  assign nbc = nb(c_r[3:0], c_r[7:4], cmd.idx[1:0]);
  assign nbp = nb(rx_r, ry_r, cmd.idx[1:0]);

  // ranges mapped through the heading; nothing is sensed behind
  always_comb begin
    sbits_in = 4'd0;
    if (in_range_front < thr_r) sbits_in = sbits_in | (4'd1 << rh_r);
    if (in_range_right < thr_r) sbits_in = sbits_in | (4'd1 << (rh_r + 2'd1));
    if (in_range_left < thr_r)  sbits_in = sbits_in | (4'd1 << (rh_r + 2'd3));
  end

  // target zero is the robot's cell, targets one to four its neighbours
  always_comb begin
    sd       = 2'(cmd.idx - 3'd1);
    nbs      = nb(rx_r, ry_r, sd);
    tgt_addr = pose_addr;
    tgt_mask = sbits_r;
    tgt_ok   = 1'b1;
    if (cmd.idx != 3'd0) begin
      tgt_addr = {nbs.y, nbs.x};
      tgt_mask = 4'd1 << (sd + 2'd2);
      tgt_ok   = sbits_r[sd] && nbs.ok;
    end
  end

  // memory port control
  always_comb begin
    w_we = 1'b0; w_wa = tgt_addr; w_wd = wall_eff | tgt_mask; w_ra = 8'd0;
    d_we = 1'b0; d_wa = clr_r;    d_wd = FAR;                 d_ra = 8'd0;
    q_we = 1'b0; q_wa = 8'd0;     q_wd = {gy, gx};            q_ra = head_r[7:0];
    case (cmd.op)
      OP_SENSE_RD: w_ra = tgt_addr;
      OP_SENSE_WR: w_we = tgt_ok;
      OP_CLR:      d_we = 1'b1;
      OP_SEED: begin
        d_we = 1'b1; d_wa = {gy, gx}; d_wd = 8'd0;
        q_we = 1'b1;
      end
      OP_CELL_RD: begin
        w_ra = q_rd;
        d_ra = q_rd;
      end
      OP_NB_RD: d_ra = {nbc.y, nbc.x};
      OP_NB_CHK: begin
        if (nok_r && (d_rd > nd_r[7:0])) begin
          d_we = 1'b1; d_wa = n_r; d_wd = nd_r[7:0];
          q_we = !tail_r[8]; q_wa = tail_r[7:0]; q_wd = n_r;
        end
      end
      OP_DEC_RD: begin
        w_ra = pose_addr;
        d_ra = pose_addr;
      end
      OP_DN_RD: d_ra = {nbp.y, nbp.x};
      default: ;
    endcase
  end

  mffn_ram #(.WIDTH(4), .DEPTH(CELLS)) u_wall (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
  );
  mffn_ram #(.WIDTH(8), .DEPTH(CELLS)) u_dist (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
  );
  mffn_ram #(.WIDTH(8), .DEPTH(CELLS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
  );

  // move choice: least of cell and open neighbours, ties forward, left, right, back
  always_comb begin
    least = cur_r;
    for (int m = 0; m < 4; m++) begin
      if (reld_r[m] < least) least = reld_r[m];
    end
    mv    = MOVE_NONE;
    found = 1'b0;
    for (int m = 0; m < 4; m++) begin
      if (!found && (reld_r[m] == least) && (cur_r != FAR)) begin
        mv    = 3'(m);
        found = 1'b1;
      end
    end
    hnew = rh_r + turn_of_move(mv[1:0]);
    nbm  = nb(rx_r, ry_r, hnew);
    if (!nbm.ok || restart_r) mv = MOVE_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RST;
      goal_x_r    <= GOAL_RST;
      goal_y_r    <= GOAL_RST;
      start_x_r   <= START_RST;
      start_y_r   <= START_RST;
      rx_r        <= 4'd0;
      ry_r        <= 4'd0;
      rh_r        <= 2'd0;
      restart_r   <= 1'b0;
      sense_r     <= 1'b0;
      head_r      <= 9'd0;
      tail_r      <= 9'd0;
      clr_r       <= 8'd0;
      wv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_r     <= cfg_data;
          CFG_GOAL_X:    goal_x_r  <= cfg_data[3:0];
          CFG_GOAL_Y:    goal_y_r  <= cfg_data[3:0];
          CFG_START_X:   start_x_r <= cfg_data[3:0];
          CFG_START_Y:   start_y_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        restart_r <= in_restart;
        sense_r   <= in_sense_walls;
        if (in_restart) begin
          rx_r <= clamp_dim(start_x_r);
          ry_r <= clamp_dim(start_y_r);
          rh_r <= 2'd0;
        end
      end
      if (w_we) wv_r[w_wa] <= 1'b1;
      case (cmd.op)
        OP_START: clr_r <= 8'd0;
        OP_CLR:   clr_r <= clr_r + 8'd1;
        OP_SEED: begin
          head_r <= 9'd0;
          tail_r <= 9'd1;
        end
        OP_NEXT: begin
          if (sts.q_more) head_r <= head_r + 9'd1;
        end
        OP_NB_CHK: begin
          if (q_we) tail_r <= tail_r + 9'd1;
        end
        default: ;
      endcase
      if (load_out) begin
        if (mv != MOVE_NONE) begin
          rx_r <= nbm.x;
          ry_r <= nbm.y;
          rh_r <= hnew;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wv_rd_r  <= wv_r[w_ra];
    w_ra_q_r <= w_ra;
    if (in_fire) sbits_r <= sbits_in;
    case (cmd.op)
      OP_CELL_RD: c_r <= q_rd;
      OP_CELL_LAT: begin
        cw_r <= wall_eff;
        nd_r <= {1'b0, d_rd} + 9'd1;
      end
      OP_NB_RD: begin
        n_r   <= {nbc.y, nbc.x};
        nok_r <= !cw_r[cmd.idx[1:0]] && nbc.ok && (nd_r < {1'b0, FAR});
      end
      OP_DEC_LAT: begin
        cur_r <= d_rd;
        pw_r  <= wall_eff;
      end
      OP_DN_RD: dok_r <= !pw_r[cmd.idx[1:0]] && nbp.ok;
      OP_DN_LAT: reld_r[move_of_rel(cmd.idx[1:0] - rh_r)] <= dok_r ? d_rd : FAR;
      default: ;
    endcase
    if (load_out) begin
      move_r     <= mv;
      px_r       <= (mv != MOVE_NONE) ? nbm.x : rx_r;
      py_r       <= (mv != MOVE_NONE) ? nbm.y : ry_r;
      ph_r       <= (mv != MOVE_NONE) ? hnew : rh_r;
      goal_hit_r <= (mv != MOVE_NONE) ? (nbm.x == gx && nbm.y == gy)
                                      : (rx_r == gx && ry_r == gy);
      dist_out_r <= cur_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_move          = move_r;
  assign out_pos_x         = px_r;
  assign out_pos_y         = py_r;
  assign out_heading       = ph_r;
  assign out_at_goal       = goal_hit_r;
  assign out_cell_distance = dist_out_r;

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue read pointer passed write pointer");
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= 9'(CELLS))
    else $error("queue overfilled");
  a_pose_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_r <= DIM_MAX) && (ry_r <= DIM_MAX))
    else $error("pose left the grid");
  a_restart_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && restart_r) |=> (move_r == MOVE_NONE))
    else $error("restart produced a move");

endmodule

// ===== hw/rtl/maze_flood_fill_navigator_unit.sv =====
// maze_flood_fill_navigator_unit: top level of the grid maze navigator
// depends on mffn_pkg, mffn_in_if, mffn_out_if, mffn_ctrl, mffn_dp (and mffn_ram below it)
//
// usage
//  - in_chan carries one navigation step per transfer: restart, sense_walls and three
//    ranges; out_chan carries one result per step: move, new pose, at_goal and the
//    flood distance of the cell the robot stood on
//  - cfg_we/cfg_index/cfg_data write the threshold, goal and start registers; write only
//    while the block is idle (in_chan.ready high and every result taken)
//  - one step at a time: the step sequencer takes a transfer only when idle
//  - step time is set by the distance clear over all 256 cells and by the flood loop,
//    which queues up to 256 cells and works through one queued cell at a time over the
//    single read port of the distance memory; sensing the walls adds to it
//  - the result sits in an output register; the next step is taken while it waits,
//    and a step that finishes while the receiver stalls waits before updating
//  - reset (synchronous, rst_n low): pose at (0,0) facing north, registers at their
//    defaults, wall map back to the outer boundary through per-cell valid bits; no
//    clearing pass needed
module maze_flood_fill_navigator_unit
  import mffn_pkg::*;
#(
  parameter int MAZE_DIM = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mffn_in_if.sink    in_chan,
  mffn_out_if.source out_chan,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  mffn_cmd_t cmd;
  mffn_sts_t sts;
  logic      in_fire;

  // ready only while the sequencer sits idle
  assign in_chan.ready = (cmd.op == OP_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  mffn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  mffn_dp #(.MAZE_DIM(MAZE_DIM)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_fire           (in_fire),
    .in_restart        (in_chan.restart),
    .in_sense_walls    (in_chan.sense_walls),
    .in_range_front    (in_chan.range_front),
    .in_range_left     (in_chan.range_left),
    .in_range_right    (in_chan.range_right),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_move          (out_chan.move),
    .out_pos_x         (out_chan.pos_x),
    .out_pos_y         (out_chan.pos_y),
    .out_heading       (out_chan.heading),
    .out_at_goal       (out_chan.at_goal),
    .out_cell_distance (out_chan.cell_distance)
  );

endmodule

// ===== tb/sv/mffn_step_checker.sv =====
// mffn_step_checker: watches the step and result channels of the navigator, predicts each
// result from its own copy of the maze state and compares; depends on mffn_pkg and the
// mffn_in_if / mffn_out_if interfaces
`timescale 1ns / 100ps

module mffn_step_checker
  import mffn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mffn_in_if         in_ch,
  mffn_out_if        out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         steps_seen,
  output int         moves_seen
);

  typedef struct packed {
    logic [2:0] move;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [1:0] heading;
    logic       at_goal;
    logic [7:0] cell_distance;
  } step_result_t;

  logic [3:0] walls [CELLS];
  logic [7:0] dmap  [CELLS];
  logic [7:0] bfs_q [CELLS];
  int         rx, ry, rh;
  logic [8:0] thr;
  logic [3:0] gx, gy, sx, sy;
  step_result_t pose_q[$];

  function automatic int cell_of(input int x, input int y);
    return ((y & 15) << 4) | (x & 15);
  endfunction

  function automatic bit step_to(input int x, input int y, input int dir,
                                 output int nx, output int ny);
    nx = x;
    ny = y;
    case (dir & 3)
      0: begin if (y + 1 >= 16) return 0; ny = y + 1; end
      1: begin if (x + 1 >= 16) return 0; nx = x + 1; end
      2: begin if (y == 0) return 0; ny = y - 1; end
      default: begin if (x == 0) return 0; nx = x - 1; end
    endcase
    return 1;
  endfunction

  task automatic reset_maze();
    for (int i = 0; i < CELLS; i++) walls[i] = 4'h0;
    for (int i = 0; i < 16; i++) begin
      walls[cell_of(i, 0)]  |= 4'h4;
      walls[cell_of(i, 15)] |= 4'h1;
      walls[cell_of(0, i)]  |= 4'h8;
      walls[cell_of(15, i)] |= 4'h2;
    end
    rx = 0; ry = 0; rh = 0;
    thr = THRESHOLD_RST; gx = GOAL_RST; gy = GOAL_RST; sx = START_RST; sy = START_RST;
  endtask

  // breadth-first distances from the goal, saturating at the unreachable mark
  task automatic flood_distances();
    int head, tail, c, nd, nx, ny, n;
    head = 0;
    tail = 1;
    for (int i = 0; i < CELLS; i++) dmap[i] = FAR;
    dmap[cell_of(gx, gy)] = 8'd0;
    bfs_q[0] = 8'(cell_of(gx, gy));
    while (head < tail && head < CELLS) begin
      c = bfs_q[head];
      head++;
      nd = dmap[c] + 1;
      if (nd >= FAR) continue;
      for (int d = 0; d < 4; d++) begin
        if (walls[c][d]) continue;
        if (!step_to(c & 15, c >> 4, d, nx, ny)) continue;
        n = cell_of(nx, ny);
        if (dmap[n] > nd) begin
          dmap[n] = 8'(nd);
          if (tail < CELLS) begin
            bfs_q[tail] = 8'(n);
            tail++;
          end
        end
      end
    end
  endtask

  task automatic predict_step(output step_result_t r);
    int cand [4];
    int least, cur, mv, nx, ny, h, bits;
    mv = MOVE_NONE;
    if (in_ch.restart) begin
      rx = sx; ry = sy; rh = 0;
      flood_distances();
      cur = dmap[cell_of(rx, ry)];
    end else begin
      if (in_ch.sense_walls) begin
        bits = 0;
        if (in_ch.range_front < thr) bits |= 1 << rh;
        if (in_ch.range_right < thr) bits |= 1 << ((rh + 1) & 3);
        if (in_ch.range_left  < thr) bits |= 1 << ((rh + 3) & 3);
        walls[cell_of(rx, ry)] |= bits[3:0];
        // far side of each sensed wall
        for (int d = 0; d < 4; d++)
          if (bits[d] && step_to(rx, ry, d, nx, ny))
            walls[cell_of(nx, ny)] |= 4'(1 << ((d + 2) & 3));
      end
      flood_distances();
      cur = dmap[cell_of(rx, ry)];
      for (int m = 0; m < 4; m++) cand[m] = FAR;
      for (int a = 0; a < 4; a++) begin
        if (walls[cell_of(rx, ry)][a]) continue;
        if (!step_to(rx, ry, a, nx, ny)) continue;
        cand[move_of_rel(2'(a - rh))] = dmap[cell_of(nx, ny)];
      end
      least = cur;
      for (int m = 0; m < 4; m++) if (cand[m] < least) least = cand[m];
      if (cur != FAR)
        for (int m = 0; m < 4; m++)
          if (cand[m] == least) begin
            mv = m;
            break;
          end
      if (mv != MOVE_NONE) begin
        h = (rh + turn_of_move(2'(mv))) & 3;
        if (step_to(rx, ry, h, nx, ny)) begin
          rh = h; rx = nx; ry = ny;
        end else begin
          mv = MOVE_NONE;
        end
      end
    end
    r.move          = 3'(mv);
    r.pos_x         = 4'(rx);
    r.pos_y         = 4'(ry);
    r.heading       = 2'(rh);
    r.at_goal       = (rx == gx && ry == gy);
    r.cell_distance = 8'(cur);
  endtask

  always @(posedge clk) begin
    step_result_t exp_r, got_r;
    if (!rst_n) begin
      reset_maze();
      pose_q.delete();
      fail_count <= 0;
      pending    <= 0;
      steps_seen <= 0;
      moves_seen <= 0;
    end else begin
      if (cfg_we)
        case (cfg_index)
          CFG_THRESHOLD: thr = cfg_data;
          CFG_GOAL_X:    gx  = cfg_data[3:0];
          CFG_GOAL_Y:    gy  = cfg_data[3:0];
          CFG_START_X:   sx  = cfg_data[3:0];
          CFG_START_Y:   sy  = cfg_data[3:0];
          default: ;
        endcase
      if (in_ch.valid && in_ch.ready) begin
        predict_step(exp_r);
        pose_q.push_back(exp_r);
        steps_seen <= steps_seen + 1;
        if (exp_r.move != MOVE_NONE) moves_seen <= moves_seen + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got_r = '{out_ch.move, out_ch.pos_x, out_ch.pos_y, out_ch.heading,
                  out_ch.at_goal, out_ch.cell_distance};
        if (pose_q.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, got_r);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = pose_q.pop_front();
          if (got_r !== exp_r) begin
            $display("%0t: mismatch expected move %0d pos (%0d,%0d) hdg %0d goal %0d dist %0d",
                     $time, exp_r.move, exp_r.pos_x, exp_r.pos_y, exp_r.heading,
                     exp_r.at_goal, exp_r.cell_distance);
            $display("%0t:          actual   move %0d pos (%0d,%0d) hdg %0d goal %0d dist %0d",
                     $time, got_r.move, got_r.pos_x, got_r.pos_y, got_r.heading,
                     got_r.at_goal, got_r.cell_distance);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= pose_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_maze_flood_fill_navigator_unit.sv =====
// tb_maze_flood_fill_navigator_unit: stimulus and verdict for the maze navigator
// depends on mffn_pkg, the channel interfaces, the block and mffn_step_checker
`timescale 1ns / 100ps

module tb_maze_flood_fill_navigator_unit;
  import mffn_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;
  logic       stall_on;   // random idling enabled for this phase
  logic [8:0] cur_thr;
  int         fail_count, pending, steps_seen, moves_seen;

  mffn_in_if  in_chan ();
  mffn_out_if out_chan ();

  maze_flood_fill_navigator_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  mffn_step_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_chan),
    .out_ch    (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending),
    .steps_seen(steps_seen),
    .moves_seen(moves_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: time for 282 steps at their slowest, taken several times over
  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver side: drops ready at random, about 15 percent of the time, while idling is on
  always @(negedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= !(stall_on && $urandom_range(99) < 15);
  end

  // one step transfer, with random gaps before it while idling is on
  task automatic send_step(input logic rs, input logic sw,
                           input logic [8:0] rf, input logic [8:0] rl, input logic [8:0] rr);
    @(negedge clk);
    while (stall_on && $urandom_range(99) < 15) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.restart     <= rs;
    in_chan.sense_walls <= sw;
    in_chan.range_front <= rf;
    in_chan.range_left  <= rl;
    in_chan.range_right <= rr;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // register write, only once the block is idle and every result is in
  task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
    @(negedge clk);
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0 || !in_chan.ready) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_THRESHOLD) cur_thr = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // a range that reads as a wall about one time in four for a low threshold
  function automatic logic [8:0] pick_range();
    if (cur_thr != 0 && $urandom_range(3) == 0) return 9'($urandom_range(cur_thr - 1));
    if (cur_thr != 9'd511 && $urandom_range(1)) return 9'($urandom_range(511, cur_thr));
    return 9'($urandom);
  endfunction

  initial begin
    logic [2:0] ri;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_THRESHOLD;
    cfg_data            = '0;
    stall_on            = 1'b0;
    cur_thr             = THRESHOLD_RST;
    in_chan.valid       = 1'b0;
    in_chan.restart     = 1'b0;
    in_chan.sense_walls = 1'b0;
    in_chan.range_front = '0;
    in_chan.range_left  = '0;
    in_chan.range_right = '0;
    out_chan.ready      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: default maze, extremes of ranges and threshold, goal and start corners
    send_step(1'b0, 1'b0, 9'd0, 9'd0, 9'd0);
    send_step(1'b0, 1'b1, 9'd511, 9'd511, 9'd511);
    send_step(1'b0, 1'b1, 9'd0, 9'd511, 9'd14);
    send_step(1'b1, 1'b1, 9'd0, 9'd0, 9'd0);
    send_step(1'b0, 1'b1, 9'd14, 9'd15, 9'd0);
    write_reg(CFG_THRESHOLD, 9'd0);
    send_step(1'b0, 1'b1, 9'd0, 9'd0, 9'd0);
    write_reg(CFG_GOAL_X, 9'd0);
    write_reg(CFG_GOAL_Y, 9'd0);
    send_step(1'b1, 1'b0, 9'd0, 9'd0, 9'd0);   // restart on the goal
    send_step(1'b0, 1'b0, 9'd0, 9'd0, 9'd0);   // already there, no move
    write_reg(CFG_START_X, 9'd15);
    write_reg(CFG_START_Y, 9'd15);
    send_step(1'b1, 1'b0, 9'd0, 9'd0, 9'd0);
    send_step(1'b0, 1'b0, 9'd0, 9'd0, 9'd0);
    write_reg(CFG_GOAL_X, 9'd15);
    write_reg(CFG_GOAL_Y, 9'd15);
    write_reg(CFG_START_X, 9'd0);
    write_reg(CFG_START_Y, 9'd15);
    send_step(1'b1, 1'b0, 9'd0, 9'd0, 9'd0);
    write_reg(CFG_THRESHOLD, 9'd511);
    // walls in the top-left corner on three sides, leaving only the south open
    send_step(1'b0, 1'b1, 9'd0, 9'd0, 9'd0);
    send_step(1'b0, 1'b0, 9'd511, 9'd511, 9'd511);
    write_reg(CFG_THRESHOLD, 9'd20);
    write_reg(CFG_START_X, 9'd0);
    write_reg(CFG_START_Y, 9'd0);
    send_step(1'b1, 1'b0, 9'd0, 9'd0, 9'd0);
    for (int i = 0; i < 4; i++) send_step(1'b0, 1'b1, 9'd300, 9'd25, 9'd5);

    // random phases: fresh registers, then well-formed walks with the odd restart
    for (int ph = 0; ph < 8; ph++) begin
      stall_on = (ph != 3);
      ri = 3'($urandom_range(4));
      write_reg(CFG_THRESHOLD, (ph == 2) ? 9'd511 : (ph == 5) ? 9'd0
                                : 9'($urandom_range(60)));
      write_reg(CFG_GOAL_X, 9'($urandom_range(15)));
      write_reg(CFG_GOAL_Y, 9'($urandom_range(15)));
      write_reg(CFG_START_X, 9'($urandom_range(15)));
      write_reg(CFG_START_Y, 9'($urandom_range(15)));
      if (ri == 0) write_reg(CFG_THRESHOLD, 9'($urandom));
      send_step(1'b1, 1'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
      for (int k = 0; k < 32; k++)
        send_step($urandom_range(99) < 8, $urandom_range(99) < 40,
                  pick_range(), pick_range(), pick_range());
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    stall_on = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);

    $display("ran %0d steps, %0d of them moving, over several goal, start and threshold settings",
             steps_seen, moves_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mffn_pkg.sv
hw/rtl/mffn_in_if.sv
hw/rtl/mffn_out_if.sv
hw/rtl/mffn_ram.sv
hw/rtl/mffn_ctrl.sv
hw/rtl/mffn_dp.sv
hw/rtl/maze_flood_fill_navigator_unit.sv
tb/sv/mffn_step_checker.sv
tb/sv/tb_maze_flood_fill_navigator_unit.sv
